// ===== rtl/lru_kvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lru_kvc_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CfgW = 5;

  localparam logic [CfgW-1:0]        CapReset  = 5'd16;
  localparam logic signed [ValW-1:0] ReadMiss  = -32'sd1;
  localparam logic signed [ValW-1:0] ReadPut   = 32'sd0;
  localparam logic signed [KeyW-1:0] NoEvictKey = 32'sd0;

  typedef enum logic {
    ActGet = 1'b0,
    ActPut = 1'b1
  } action_e;

  // Per-entry update command driven by the access logic
  typedef struct packed {
    logic set_valid;
    logic load_key;
    logic load_value;
    logic zero_rank;
    logic age;
  } lane_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lru_kvc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lru_kvc_req_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      action;
  logic signed [lru_kvc_pkg::KeyW-1:0]       lookup_key;
  logic signed [lru_kvc_pkg::ValW-1:0]       write_value;

  modport source (output valid, action, lookup_key, write_value, input ready);
  modport sink   (input valid, action, lookup_key, write_value, output ready);
endinterface

interface lru_kvc_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      hit;
  logic signed [lru_kvc_pkg::ValW-1:0]       read_value;
  logic                                      evicted;
  logic signed [lru_kvc_pkg::KeyW-1:0]       evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lru_kvc_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic [lru_kvc_pkg::CfgW-1:0]              active_capacity;

  modport source (output valid, active_capacity, input ready);
  modport sink   (input valid, active_capacity, output ready);
endinterface

`default_nettype wire

// ===== rtl/lru_kvc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lru_kvc_lane #(
  parameter int unsigned RankW = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire lru_kvc_pkg::lane_cmd_t              cmd_i,
  input  wire logic signed [lru_kvc_pkg::KeyW-1:0] key_i,
  input  wire logic signed [lru_kvc_pkg::ValW-1:0] value_i,
  output logic                                     valid_o,
  output logic                                     match_o,
  output logic [RankW-1:0]                         rank_o,
  output logic signed [lru_kvc_pkg::KeyW-1:0]      key_o,
  output logic signed [lru_kvc_pkg::ValW-1:0]      value_o
);
  import lru_kvc_pkg::*;

  logic                   valid_q;
  logic signed [KeyW-1:0] key_q;
  logic signed [ValW-1:0] value_q;
  logic [RankW-1:0]       rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.set_valid) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= key_i;
    end
    if (cmd_i.load_value) begin
      value_q <= value_i;
    end
    if (cmd_i.zero_rank) begin
      rank_q <= '0;
    end else if (cmd_i.age) begin
      rank_q <= rank_q + RankW'(1);
    end
  end

  assign valid_o = valid_q;
  assign match_o = valid_q && (key_q == key_i);
  assign rank_o  = rank_q;
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// LRU key-value cache, fully associative, CAPACITY entries.
// req (sink): one beat per access; action 0 = get, 1 = put, with lookup_key
//   and write_value. rsp (source): one beat per access, in order, giving hit,
//   read_value (value on get hit, -1 on get miss, 0 on put), evicted and
//   evicted_key (0 when nothing was evicted).
// cfg (sink): writes active_capacity; always ready. 0 acts as 1 and values
//   above CAPACITY act as CAPACITY. Write it only while the cache is idle.
// Path: an accepted request beat passes the request register, then the
//   response register, which loads it when the response side is not stalled.
// Throughput: one access per cycle unless rsp stalls. The match, recency-rank
//   update and slot pick for all entries happen in one pass between the
//   request register and the response register; the entry state is updated
//   at the same edge, so the following access sees it.
// Reset: all entries invalid, fill count zero, active_capacity back to 16.
// Stall: the response register holds its beat while rsp.ready is low; one
//   more request is held in the request register, after which req.ready
//   drops until the response drains.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  lru_kvc_req_if.sink   req,
  lru_kvc_rsp_if.source rsp,
  lru_kvc_cfg_if.sink   cfg
);
  import lru_kvc_pkg::*;

  localparam int unsigned RankW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (CntW > CfgW) ? CntW : CfgW;

  // configuration
  logic [CfgW-1:0] cap_q;
  logic [CmpW-1:0] cap_ext, eff_cap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg.valid) begin
      cap_q <= cfg.active_capacity;
    end
  end

  assign cap_ext = CmpW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(CAPACITY)) begin
      eff_cap = CmpW'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // request register
  logic                   in_valid_q;
  action_e                act_q;
  logic signed [KeyW-1:0] key_q;
  logic signed [ValW-1:0] val_q;
  logic                   out_valid_q;
  logic                   advance;

  assign advance   = in_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req.ready) begin
      in_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      act_q <= action_e'(req.action);
      key_q <= req.lookup_key;
      val_q <= req.write_value;
    end
  end

  // entry lanes
  lane_cmd_t              cmd   [CAPACITY];
  logic [CAPACITY-1:0]    valid_vec, match_vec, oldest_vec, tgt_vec;
  logic [RankW-1:0]       rank  [CAPACITY];
  logic signed [KeyW-1:0] lkey  [CAPACITY];
  logic signed [ValW-1:0] lval  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_lane
    lru_kvc_lane #(
      .RankW(RankW)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[g]),
      .key_i   (key_q),
      .value_i (val_q),
      .valid_o (valid_vec[g]),
      .match_o (match_vec[g]),
      .rank_o  (rank[g]),
      .key_o   (lkey[g]),
      .value_o (lval[g])
    );
  end

  // access logic
  logic [CntW-1:0]        count_q, count_d;
  logic [RankW-1:0]       hit_rank, oldest_rank;
  logic signed [ValW-1:0] hit_val;
  logic signed [KeyW-1:0] ev_key;
  logic [CAPACITY-1:0]    free_vec, pick_vec;
  logic                   hit, is_put, full, evict, ins;

  assign is_put      = (act_q == ActPut);
  assign hit         = |match_vec;
  assign full        = CmpW'(count_q) >= eff_cap;
  assign oldest_rank = RankW'(count_q - CntW'(1));
  assign free_vec    = ~valid_vec;

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      oldest_vec[i] = valid_vec[i] && (rank[i] == oldest_rank);
      if (match_vec[i]) begin
        hit_rank = hit_rank | rank[i];
        hit_val  = hit_val | lval[i];
      end
    end
  end

  assign evict    = is_put && !hit && full && (|oldest_vec);
  assign pick_vec = evict ? oldest_vec : free_vec;
  // lowest set bit wins
  assign tgt_vec  = pick_vec & (~pick_vec + CAPACITY'(1));
  assign ins      = is_put && !hit && (|tgt_vec);

  always_comb begin
    ev_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tgt_vec[i]) begin
        ev_key = ev_key | lkey[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i] = '0;
      if (advance) begin
        if (hit) begin
          cmd[i].zero_rank  = match_vec[i];
          cmd[i].load_value = match_vec[i] && is_put;
          cmd[i].age        = valid_vec[i] && !match_vec[i] && (rank[i] < hit_rank);
        end else if (ins) begin
          cmd[i].set_valid  = tgt_vec[i];
          cmd[i].load_key   = tgt_vec[i];
          cmd[i].load_value = tgt_vec[i];
          cmd[i].zero_rank  = tgt_vec[i];
          cmd[i].age        = valid_vec[i] && !tgt_vec[i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (advance && ins && !evict) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // response register
  logic                   hit_q, evicted_q;
  logic signed [ValW-1:0] rd_q;
  logic signed [KeyW-1:0] evk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit_q     <= hit;
      evicted_q <= evict;
      evk_q     <= evict ? ev_key : NoEvictKey;
      if (is_put) begin
        rd_q <= ReadPut;
      end else if (hit) begin
        rd_q <= hit_val;
      end else begin
        rd_q <= ReadMiss;
      end
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.hit         = hit_q;
  assign rsp.read_value  = rd_q;
  assign rsp.evicted     = evicted_q;
  assign rsp.evicted_key = evk_q;

endmodule

`default_nettype wire

// ===== rtl/lru_kvc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lru_kvc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                req_valid_i,
  input wire logic                                req_ready_i,
  input wire logic                                rsp_valid_i,
  input wire logic                                rsp_ready_i,
  input wire logic                                rsp_hit_i,
  input wire logic signed [lru_kvc_pkg::ValW-1:0] rsp_read_value_i,
  input wire logic                                rsp_evicted_i,
  input wire logic signed [lru_kvc_pkg::KeyW-1:0] rsp_evicted_key_i
);
  import lru_kvc_pkg::*;

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i)
      && $stable(rsp_read_value_i) && $stable(rsp_evicted_i)
      && $stable(rsp_evicted_key_i))
    else $error("response beat changed while stalled");

  // eviction only on a put of a new key
  a_evict_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_evicted_i |-> !rsp_hit_i && (rsp_read_value_i == ReadPut))
    else $error("eviction reported on a hit or a get");

  a_no_evict_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_evicted_i |-> rsp_evicted_key_i == NoEvictKey)
    else $error("evicted key not zero without eviction");

  // a response beat follows an accepted request when the response side keeps up
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i ##1 (!rsp_valid_i || rsp_ready_i) |=> rsp_valid_i)
    else $error("response beat missing after accepted request");

endmodule

bind lru_key_value_cache lru_kvc_checker u_lru_kvc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_hit_i         (rsp.hit),
  .rsp_read_value_i  (rsp.read_value),
  .rsp_evicted_i     (rsp.evicted),
  .rsp_evicted_key_i (rsp.evicted_key)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lru_kvc_pkg::*;

  localparam int unsigned Slots      = 16;
  localparam int unsigned HoldCycles = 50;
  localparam logic [KeyW-1:0] KeyMin = 32'h8000_0000;
  localparam logic [KeyW-1:0] KeyMax = 32'h7FFF_FFFF;

  typedef struct {
    logic                   hit;
    logic signed [ValW-1:0] read_value;
    logic                   evicted;
    logic signed [KeyW-1:0] evicted_key;
  } cache_rsp_t;

  logic clk_i;
  logic rst_ni;

  lru_kvc_req_if req_if ();
  lru_kvc_rsp_if rsp_if ();
  lru_kvc_cfg_if cfg_if ();

  lru_key_value_cache #(
    .CAPACITY (Slots)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  // Shadow copy of the cache contents
  bit                slot_valid [Slots];
  logic [KeyW-1:0]   slot_key   [Slots];
  logic [ValW-1:0]   slot_value [Slots];
  int unsigned       slot_rank  [Slots];
  int unsigned       fill_level;
  logic [CfgW-1:0]   cap_reg;

  cache_rsp_t        cache_rsp_q [$];
  logic [KeyW-1:0]   key_pool [$];
  int unsigned       fail_count;
  bit                req_idle_on;
  bit                rsp_idle_on;
  int unsigned       hold_seq;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly no gap, some short ones, the odd long one
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Works out the response of one access and updates the shadow state
  function automatic cache_rsp_t lru_access(input action_e act, input logic [KeyW-1:0] key,
                                            input logic [ValW-1:0] value);
    cache_rsp_t  r;
    int          slot;
    int unsigned eff_cap;
    int unsigned pivot;
    r.hit         = 1'b0;
    r.read_value  = ReadPut;
    r.evicted     = 1'b0;
    r.evicted_key = NoEvictKey;
    slot          = -1;
    for (int i = 0; i < Slots; i++) begin
      if (slot < 0 && slot_valid[i] && slot_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      r.hit = 1'b1;
      pivot = slot_rank[slot];
      for (int i = 0; i < Slots; i++) begin
        if (slot_valid[i] && slot_rank[i] < pivot) slot_rank[i]++;
      end
      slot_rank[slot] = 0;
      if (act == ActPut) slot_value[slot] = value;
      else r.read_value = slot_value[slot];
    end else if (act == ActGet) begin
      r.read_value = ReadMiss;
    end else begin
      eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > Slots) ? Slots : 32'(cap_reg));
      if (fill_level >= eff_cap) begin
        for (int i = 0; i < Slots; i++) begin
          if (slot < 0 && slot_valid[i] && slot_rank[i] == fill_level - 1) slot = i;
        end
        if (slot >= 0) begin
          r.evicted     = 1'b1;
          r.evicted_key = slot_key[slot];
          slot_valid[slot] = 1'b0;
          fill_level--;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < Slots; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_valid[i]) slot_rank[i]++;
        end
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = value;
        slot_rank[slot]  = 0;
        fill_level++;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
             $signed(exp_v), $signed(act_v));
  endtask

  // Response side: random stalls, plus a long hold when a test asks for one
  initial begin : rsp_ready_drive
    int unsigned stall_left;
    int unsigned hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen  = hold_seq;
        stall_left = HoldCycles;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(rsp_idle_on);
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : rsp_check
    cache_rsp_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        if (cache_rsp_q.size() == 0) begin
          fail_count++;
          $display("%0t: response beat with nothing outstanding, hit %0b value %0d",
                   $time, rsp_if.hit, rsp_if.read_value);
        end else begin
          want = cache_rsp_q.pop_front();
          if (rsp_if.hit !== want.hit)
            flag_mismatch("hit", 32'(want.hit), 32'(rsp_if.hit));
          if (rsp_if.read_value !== want.read_value)
            flag_mismatch("read_value", want.read_value, rsp_if.read_value);
          if (rsp_if.evicted !== want.evicted)
            flag_mismatch("evicted", 32'(want.evicted), 32'(rsp_if.evicted));
          if (rsp_if.evicted_key !== want.evicted_key)
            flag_mismatch("evicted_key", want.evicted_key, rsp_if.evicted_key);
        end
      end
    end
  end

  // valid is left high after a beat so back-to-back accesses need no toggle
  task automatic send_access(input action_e act, input logic [KeyW-1:0] key,
                             input logic [ValW-1:0] value);
    int unsigned gap;
    gap = pick_gap(req_idle_on);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.lookup_key  <= key;
    req_if.write_value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    cache_rsp_q.push_back(lru_access(act, key, value));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (cache_rsp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CfgW-1:0] cap);
    cfg_if.valid           <= 1'b1;
    cfg_if.active_capacity <= cap;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cap_reg = cap;
  endtask

  task automatic build_key_pool(input int unsigned n);
    int unsigned r;
    key_pool.delete();
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r == 0) key_pool.push_back(KeyMin);
      else if (r == 1) key_pool.push_back(KeyMax);
      else key_pool.push_back($urandom);
    end
  endtask

  // One configuration, then a stream of gets and puts over a small key set
  task automatic run_lru_phase(input logic [CfgW-1:0] cap, input int unsigned n_items,
                               input int unsigned pool_n, input int unsigned put_pct,
                               input bit req_idle, input bit rsp_idle);
    action_e         act;
    logic [KeyW-1:0] key;
    wait_drained();
    write_capacity(cap);
    req_idle_on = req_idle;
    rsp_idle_on = rsp_idle;
    build_key_pool(pool_n);
    repeat (n_items) begin
      act = ($urandom_range(0, 99) < put_pct) ? ActPut : ActGet;
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      send_access(act, key, $urandom);
    end
  endtask

  task automatic test_extremes();
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    send_access(ActGet, 32'h0, 32'h0);
    send_access(ActPut, KeyMax, KeyMin);
    send_access(ActPut, KeyMin, KeyMax);
    send_access(ActPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(ActPut, 32'h0, 32'h0);
    send_access(ActGet, KeyMax, 32'hFFFF_FFFF);
    send_access(ActGet, KeyMin, 32'h0);
    send_access(ActGet, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_access(ActGet, 32'h0, 32'h0);
    send_access(ActPut, 32'h0, 32'h1234_5678);
    send_access(ActGet, 32'h0, 32'h0);
    send_access(ActGet, 32'h1, 32'h0);
  endtask

  // Lower the capacity under the fill level: each new key evicts one entry
  task automatic test_capacity_shrink();
    wait_drained();
    write_capacity(5'd2);
    send_access(ActPut, 32'h0000_0011, 32'hA5A5_0011);
    send_access(ActPut, 32'h0000_0022, 32'hA5A5_0022);
    send_access(ActGet, 32'h0000_0011, 32'h0);
    wait_drained();
    write_capacity(5'd0);
    send_access(ActPut, 32'h0000_0033, 32'hA5A5_0033);
    send_access(ActGet, 32'h0000_0022, 32'h0);
  endtask

  task automatic test_capacity_limits();
    run_lru_phase(5'd1, 120, 3, 50, 1'b1, 1'b1);
    run_lru_phase(5'd0, 100, 2, 50, 1'b1, 1'b1);
    run_lru_phase(5'd31, 200, 20, 50, 1'b0, 1'b0);
    run_lru_phase(5'd17, 150, 18, 60, 1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    write_capacity(5'd4);
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    build_key_pool(6);
    hold_seq++;
    repeat (30) send_access(($urandom_range(0, 1) != 0) ? ActPut : ActGet,
                            key_pool[$urandom_range(0, 5)], $urandom);
    // sender waits here for every outstanding beat
    wait_drained();
    repeat (20) send_access(($urandom_range(0, 1) != 0) ? ActPut : ActGet,
                            key_pool[$urandom_range(0, 5)], $urandom);
  endtask

  task automatic test_random_traffic();
    logic [CfgW-1:0] cap;
    run_lru_phase(5'd16, 200, 24, 50, 1'b1, 1'b1);
    repeat (3) begin
      cap = CfgW'($urandom_range(2, 15));
      run_lru_phase(cap, 150, cap + $urandom_range(1, 6), 45, 1'b1, 1'b1);
    end
    run_lru_phase(5'd16, 200, 40, 40, 1'b0, 1'b1);
    run_lru_phase(5'd8, 150, 10, 55, 1'b1, 1'b0);
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    req_if.valid           <= 1'b0;
    req_if.action          <= ActGet;
    req_if.lookup_key      <= '0;
    req_if.write_value     <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.active_capacity <= CapReset;
    for (int i = 0; i < Slots; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_rank[i]  = 0;
    end
    fill_level  = 0;
    cap_reg     = CapReset;
    fail_count  = 0;
    hold_seq    = 0;
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_capacity_shrink();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
